// File: rtl/core/dct2d_pkg.sv
// Shared types, widths and the basis coefficient table of the 8x8 DCT block.
// No dependencies; the sequencer, datapath, top level and testbench import this package.
package dct2d_pkg;

  // Block geometry. The cosine table below holds the points of an 8-point transform.
  localparam int BLOCK_DIM  = 8;
  localparam int BLOCK_SIZE = BLOCK_DIM * BLOCK_DIM;
  localparam int IDX_W      = $clog2(BLOCK_DIM);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int FILL_W     = $clog2(BLOCK_SIZE + 1);

  // Datapath widths.
  localparam int SAMPLE_W  = 8;
  localparam int BASIS_W   = 15;
  localparam int PART_W    = 25;
  localparam int PROD_W    = PART_W + BASIS_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int COEF_W    = 29;
  localparam int FREQ_W    = 3;
  localparam int PROD_FRAC = 28;
  localparam int FRAC_BITS_DEF = 16;

  // Folding of the cosine argument into the first quadrant.
  localparam int FOUR_D = 4 * BLOCK_DIM;
  localparam int RW     = $clog2(FOUR_D);
  localparam int CIW    = $clog2(BLOCK_DIM + 1);

  // Half of cos(pi*k/16) in Q1.14, k = 0 .. 8.
  localparam logic [BASIS_W-1:0] COS_Q14 [0:BLOCK_DIM] = '{
    15'd8192, 15'd8035, 15'd7568, 15'd6811, 15'd5793,
    15'd4551, 15'd3135, 15'd1598, 15'd0
  };
  // Half of sqrt(1/2) in Q1.14, the factor of the zero frequency row.
  localparam logic [BASIS_W-1:0] DC_Q14 = 15'd5793;

  // One multiply-accumulate step issued by the sequencer.
  typedef struct packed {
    logic             valid;
    logic             col;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] k;
  } issue_t;

  // Basis factor f(u,x) = c(u)/2 * cos((2x+1)*u*pi/16) in signed Q1.14.
  function automatic logic signed [BASIS_W-1:0] basis_coef(input logic [IDX_W-1:0] u,
                                                           input logic [IDX_W-1:0] x);
    logic [RW-1:0]      r;
    logic               neg;
    logic [BASIS_W-1:0] mag;
    r   = RW'(((2 * x + 1) * u) % FOUR_D);
    neg = 1'b0;
    if (r > RW'(2 * BLOCK_DIM)) begin
      r = RW'(FOUR_D) - r;
    end
    if (r > RW'(BLOCK_DIM)) begin
      neg = 1'b1;
      r   = RW'(2 * BLOCK_DIM) - r;
    end
    mag = (u == '0) ? DC_Q14 : COS_Q14[r[CIW-1:0]];
    return neg ? -signed'(mag) : signed'(mag);
  endfunction

endpackage

// File: rtl/core/dct_8x8_2d.sv
// Top level of the 8x8 two-dimensional DCT-II block.
// Depends on dct2d_pkg, dct2d_ram, dct2d_seq and dct2d_mac.
//
// Input channel (in_valid / in_stall / in_sample): 64 unsigned samples of one
// block in row-major order, one transfer per cycle while a block fills.
// Output channel (out_valid / out_stall / out_*): the 64 coefficients in
// row-major order with frequency indexes; out_block_end marks the last one.
// After the 64th sample a row pass runs through the single shared multiplier,
// reading the sample RAM; the input is stalled meanwhile. A column pass then
// reads the partial-sum RAM and gives the coefficients one by one. Samples of
// the next block are taken during the column pass; the one multiplier does
// 1024 multiply-accumulates per block.
// Reset clears the fill count and the sequencer and drops a partial block;
// the RAM contents are kept. A stalled output freezes the compute pipeline.
module dct_8x8_2d
  import dct2d_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SAMPLE_W-1:0]      in_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [COEF_W-1:0] out_coefficient,
  output logic [FREQ_W-1:0]        out_freq_row,
  output logic [FREQ_W-1:0]        out_freq_col,
  output logic                     out_block_end
);

  issue_t                   iss;
  logic                     hold;
  logic                     smp_wr_en;
  logic [ADDR_W-1:0]        smp_wr_addr, smp_rd_addr;
  logic [SAMPLE_W-1:0]      smp_wr_data, smp_rdata;
  logic                     part_wr_en;
  logic [ADDR_W-1:0]        part_wr_addr, part_rd_addr;
  logic [PART_W-1:0]        part_wr_data, part_rdata;

  // Fill control and step sequencing.
  dct2d_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .hold         (hold),
    .smp_wr_en    (smp_wr_en),
    .smp_wr_addr  (smp_wr_addr),
    .smp_wr_data  (smp_wr_data),
    .smp_rd_addr  (smp_rd_addr),
    .part_rd_addr (part_rd_addr),
    .iss          (iss)
  );

  // Sample store of one block.
  dct2d_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BLOCK_SIZE)
  ) u_smp_ram (
    .clk     (clk),
    .wr_en   (smp_wr_en),
    .wr_addr (smp_wr_addr),
    .wr_data (smp_wr_data),
    .rd_en   (!hold),
    .rd_addr (smp_rd_addr),
    .rd_data (smp_rdata)
  );

  // Row transform results.
  dct2d_ram #(
    .WIDTH (PART_W),
    .DEPTH (BLOCK_SIZE)
  ) u_part_ram (
    .clk     (clk),
    .wr_en   (part_wr_en),
    .wr_addr (part_wr_addr),
    .wr_data (part_wr_data),
    .rd_en   (!hold),
    .rd_addr (part_rd_addr),
    .rd_data (part_rdata)
  );

  // Multiply-accumulate datapath and output register.
  dct2d_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk             (clk),
    .rst_n           (rst_n),
    .iss             (iss),
    .smp_rdata       (smp_rdata),
    .part_rdata      (signed'(part_rdata)),
    .hold            (hold),
    .part_wr_en      (part_wr_en),
    .part_wr_addr    (part_wr_addr),
    .part_wr_data    (part_wr_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_coefficient (out_coefficient),
    .out_freq_row    (out_freq_row),
    .out_freq_col    (out_freq_col),
    .out_block_end   (out_block_end)
  );

endmodule

// File: rtl/core/dct2d_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module dct2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/dct2d_seq.sv
// Sample fill control and multiply-accumulate sequencer of the DCT block.
// Depends on dct2d_pkg; drives the sample RAM write port and both read addresses.
module dct2d_seq
  import dct2d_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                hold,
  output logic                smp_wr_en,
  output logic [ADDR_W-1:0]   smp_wr_addr,
  output logic [SAMPLE_W-1:0] smp_wr_data,
  output logic [ADDR_W-1:0]   smp_rd_addr,
  output logic [ADDR_W-1:0]   part_rd_addr,
  output issue_t              iss
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ROW  = 2'd1;
  localparam logic [1:0] PH_COL  = 2'd2;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(BLOCK_DIM - 1);

  logic [1:0]       phase_r, phase_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic             full_r, full_nxt;
  logic [IDX_W-1:0] a_r, a_nxt, b_r, b_nxt, k_r, k_nxt;
  logic             in_xfer;

  // Samples are held off while a full block waits and during the row pass.
  assign in_stall    = full_r || (phase_r == PH_ROW);
  assign in_xfer     = in_valid && !in_stall;
  assign smp_wr_en   = in_xfer;
  assign smp_wr_addr = fill_r[ADDR_W-1:0];
  assign smp_wr_data = in_sample;

  // Row pass reads sample (x, y); column pass reads partial (u, y).
  assign smp_rd_addr  = {k_r, b_r};
  assign part_rd_addr = {a_r, k_r};

  assign iss.valid = (phase_r != PH_IDLE);
  assign iss.col   = (phase_r == PH_COL);
  assign iss.first = (k_r == '0);
  assign iss.last  = (k_r == IDX_MAX);
  assign iss.a     = a_r;
  assign iss.b     = b_r;
  assign iss.k     = k_r;

  // Next-state logic of the fill counter and the three nested step counters.
  always_comb begin
    phase_nxt = phase_r;
    fill_nxt  = fill_r;
    full_nxt  = full_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    k_nxt     = k_r;

    if (in_xfer) begin
      if (fill_r == FILL_W'(BLOCK_SIZE - 1)) begin
        fill_nxt = '0;
        full_nxt = 1'b1;
      end else begin
        fill_nxt = fill_r + 1'b1;
      end
    end

    if (phase_r == PH_IDLE) begin
      if (full_r) begin
        phase_nxt = PH_ROW;
        full_nxt  = 1'b0;
      end
    end else if (!hold) begin
      if (k_r != IDX_MAX) begin
        k_nxt = k_r + 1'b1;
      end else begin
        k_nxt = '0;
        if (b_r != IDX_MAX) begin
          b_nxt = b_r + 1'b1;
        end else begin
          b_nxt = '0;
          if (a_r != IDX_MAX) begin
            a_nxt = a_r + 1'b1;
          end else begin
            a_nxt     = '0;
            phase_nxt = (phase_r == PH_ROW) ? PH_COL : PH_IDLE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      fill_r  <= '0;
      full_r  <= 1'b0;
      a_r     <= '0;
      b_r     <= '0;
      k_r     <= '0;
    end else begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      full_r  <= full_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      k_r     <= k_nxt;
    end
  end

  // A new block cannot complete while the row pass still reads the sample store.
  a_row_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ROW) |-> !full_r)
    else $error("block completed during row pass");

  // A held pipeline keeps the step counters where they are.
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (hold && phase_r != PH_IDLE) |=> $stable({phase_r, a_r, b_r, k_r}))
    else $error("step counters moved while pipeline held");

endmodule

// File: rtl/core/dct2d_mac.sv
// Shared multiply-accumulate datapath, rounding, saturation and output register.
// Depends on dct2d_pkg; reads both RAMs and writes the partial-sum RAM.
module dct2d_mac
  import dct2d_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  issue_t                   iss,
  input  logic [SAMPLE_W-1:0]      smp_rdata,
  input  logic signed [PART_W-1:0] part_rdata,
  output logic                     hold,
  output logic                     part_wr_en,
  output logic [ADDR_W-1:0]        part_wr_addr,
  output logic [PART_W-1:0]        part_wr_data,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic signed [COEF_W-1:0] out_coefficient,
  output logic [FREQ_W-1:0]        out_freq_row,
  output logic [FREQ_W-1:0]        out_freq_col,
  output logic                     out_block_end
);

  localparam int OUT_SHIFT = PROD_FRAC - FRAC_BITS;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (OUT_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(2 ** (COEF_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO   = ~SAT_HI;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(BLOCK_DIM - 1);

  issue_t                    s1_r, s2_r;
  logic signed [BASIS_W-1:0] s1_basis_r;
  logic signed [PART_W-1:0]  op_a;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      s3_done_r, s3_col_r;
  logic [IDX_W-1:0]          s3_a_r, s3_b_r;
  logic                      fin, out_load;
  logic signed [ACC_W-1:0]   rnd_sum, rnd_shift, coef_sat;
  logic                      out_valid_r;

  // The whole pipeline waits while a finished coefficient is stalled.
  assign hold = out_valid_r && out_stall;

  // Stage 1: basis factor, aligned with the RAM read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (!hold) begin
      s1_r       <= iss;
      s1_basis_r <= iss.col ? basis_coef(iss.b, iss.k) : basis_coef(iss.a, iss.k);
    end
  end

  // Stage 2: one shared multiplier, registered product.
  assign op_a = s1_r.col ? part_rdata
                         : signed'({{(PART_W - SAMPLE_W){1'b0}}, smp_rdata});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (!hold) begin
      s2_r   <= s1_r;
      prod_r <= op_a * s1_basis_r;
    end
  end

  // Stage 3: accumulate eight products of one sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_done_r <= 1'b0;
    end else if (!hold) begin
      s3_done_r <= s2_r.valid && s2_r.last;
      if (s2_r.valid) begin
        acc_r    <= s2_r.first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
        s3_col_r <= s2_r.col;
        s3_a_r   <= s2_r.a;
        s3_b_r   <= s2_r.b;
      end
    end
  end

  // Stage 4: a finished row sum goes to the partial RAM, a column sum to the output.
  assign fin          = s3_done_r && !hold;
  assign part_wr_en   = fin && !s3_col_r;
  assign part_wr_addr = {s3_a_r, s3_b_r};
  assign part_wr_data = acc_r[PART_W-1:0];
  assign out_load     = fin && s3_col_r;

  // Round half up, then saturate to the coefficient range.
  always_comb begin
    rnd_sum   = acc_r + RND_HALF;
    rnd_shift = rnd_sum >>> OUT_SHIFT;
    if (rnd_shift > SAT_HI) begin
      coef_sat = SAT_HI;
    end else if (rnd_shift < SAT_LO) begin
      coef_sat = SAT_LO;
    end else begin
      coef_sat = rnd_shift;
    end
  end

  // Output register: loads when empty or while its content is transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_coefficient <= coef_sat[COEF_W-1:0];
      out_freq_row    <= FREQ_W'(s3_a_r);
      out_freq_col    <= FREQ_W'(s3_b_r);
      out_block_end   <= (s3_a_r == IDX_MAX) && (s3_b_r == IDX_MAX);
    end
  end

  assign out_valid = out_valid_r;

  // A held pipeline keeps its pending sum intact.
  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    hold |=> ($stable(acc_r) && $stable(s3_done_r)))
    else $error("accumulator changed while pipeline held");

endmodule

// File: tb/sv/tb_dct_8x8_2d.sv
// Self-checking testbench for dct_8x8_2d, the 8x8 two-dimensional DCT-II block.
// Depends on dct2d_pkg and the RTL of dct_8x8_2d. It predicts every coefficient
// in fixed point and checks each output transfer field by field.
`timescale 1ns / 100ps

module tb_dct_8x8_2d;
  import dct2d_pkg::*;

  localparam int    COEF_FRAC   = 16;
  localparam int    ROUND_SHIFT = 28 - COEF_FRAC;
  localparam longint COEF_HI    = (64'sd1 <<< (COEF_W - 1)) - 1;
  localparam longint COEF_LO    = -(64'sd1 <<< (COEF_W - 1));
  localparam real   PI_VAL      = 3.14159265358979323846;
  localparam int    HOLD_CYCLES = 4000;
  localparam int    RAND_BLOCKS = 2;

  // Sample patterns of one block.
  typedef enum logic [3:0] {
    PAT_FLAT, PAT_CHECKER, PAT_IMPULSE, PAT_RAMP,
    PAT_UNIFORM, PAT_EXTREME, PAT_LOW, PAT_ONEBIT
  } pattern_e;

  // One row of the directed table. A typed row has a flat block, so its
  // AC coefficients are zero and its DC value is given here.
  typedef struct packed {
    pattern_e                  pat;
    logic [SAMPLE_W-1:0]       level;
    logic                      typed;
    logic signed [COEF_W-1:0]  dc;
  } dir_row_t;

  typedef struct packed {
    logic                      typed;
    logic signed [COEF_W-1:0]  dc;
  } block_note_t;

  typedef struct packed {
    logic signed [COEF_W-1:0]  coef;
    logic [FREQ_W-1:0]         row;
    logic [FREQ_W-1:0]         col;
    logic                      last;
  } coef_entry_t;

  localparam dir_row_t DIRECTED [3] = '{
    '{PAT_FLAT,    8'd0,   1'b1, 29'sd0},
    '{PAT_FLAT,    8'd255, 1'b1, 29'sd133711039},
    '{PAT_CHECKER, 8'd255, 1'b0, 29'sd0}
  };

  localparam pattern_e RAND_PATS [4] = '{PAT_UNIFORM, PAT_EXTREME, PAT_LOW, PAT_ONEBIT};

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [SAMPLE_W-1:0]      in_sample;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [COEF_W-1:0] out_coefficient;
  logic [FREQ_W-1:0]        out_freq_row;
  logic [FREQ_W-1:0]        out_freq_col;
  logic                     out_block_end;

  // Predictor state: basis factors, the pixel store and its fill count.
  int                  basis_q14 [BLOCK_DIM][BLOCK_DIM];
  logic [SAMPLE_W-1:0] pixel_store [BLOCK_SIZE];
  int                  fill_cnt = 0;
  block_note_t         block_note_q [$];
  coef_entry_t         coef_expect_q [$];
  coef_entry_t         want_coef;
  int                  mismatch_count = 0;
  bit                  quiet = 1'b0;
  bit                  hold_req = 1'b0;

  dct_8x8_2d #(
    .FRAC_BITS(COEF_FRAC)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_coefficient (out_coefficient),
    .out_freq_row    (out_freq_row),
    .out_freq_col    (out_freq_col),
    .out_block_end   (out_block_end)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Stores one sample; a full block yields all 64 expected coefficients.
  task automatic take_sample(input logic [SAMPLE_W-1:0] s);
    longint      row_sum [BLOCK_DIM][BLOCK_DIM];
    longint      acc;
    longint      c;
    block_note_t note;
    coef_entry_t e;
    pixel_store[fill_cnt] = s;
    fill_cnt++;
    if (fill_cnt == BLOCK_SIZE) begin
      fill_cnt = 0;
      note = block_note_q.pop_front();
      // Transform down the columns first, then along each row.
      for (int u = 0; u < BLOCK_DIM; u++) begin
        for (int y = 0; y < BLOCK_DIM; y++) begin
          acc = 0;
          for (int x = 0; x < BLOCK_DIM; x++) begin
            acc += longint'(basis_q14[u][x]) * longint'(pixel_store[x * BLOCK_DIM + y]);
          end
          row_sum[u][y] = acc;
        end
      end
      for (int u = 0; u < BLOCK_DIM; u++) begin
        for (int v = 0; v < BLOCK_DIM; v++) begin
          acc = 0;
          for (int y = 0; y < BLOCK_DIM; y++) begin
            acc += row_sum[u][y] * longint'(basis_q14[v][y]);
          end
          c = (acc + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
          if (c > COEF_HI) c = COEF_HI;
          if (c < COEF_LO) c = COEF_LO;
          if (note.typed) begin
            c = (u == 0 && v == 0) ? longint'(note.dc) : 0;
          end
          e.coef = c[COEF_W-1:0];
          e.row  = u[FREQ_W-1:0];
          e.col  = v[FREQ_W-1:0];
          e.last = (u == BLOCK_DIM - 1 && v == BLOCK_DIM - 1);
          coef_expect_q.push_back(e);
        end
      end
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] block_pixel(input pattern_e p,
                                                      input logic [SAMPLE_W-1:0] level,
                                                      input int idx);
    case (p)
      PAT_FLAT:    return level;
      PAT_CHECKER: return (((idx >> 3) ^ idx) & 1) ? level : 8'd0;
      PAT_IMPULSE: return (idx == BLOCK_SIZE - 1) ? level : 8'd0;
      PAT_RAMP:    return 8'(idx * 4);
      PAT_UNIFORM: return 8'($urandom);
      PAT_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PAT_LOW:     return 8'($urandom_range(0, 15));
      PAT_ONEBIT:  return 8'd1 << $urandom_range(0, 7);
      default:     return 8'd0;
    endcase
  endfunction

  // One input transfer, with a random gap ahead of it unless the run is quiet.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_block(input pattern_e p, input logic [SAMPLE_W-1:0] level,
                            input logic typed, input logic signed [COEF_W-1:0] dc);
    block_note_q.push_back('{typed, dc});
    for (int i = 0; i < BLOCK_SIZE; i++) begin
      send_sample(block_pixel(p, level, i));
    end
  endtask

  // The sender rests until every expected coefficient has come out.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (coef_expect_q.size() != 0) @(posedge clk);
  endtask

  // Every input transfer feeds the predictor.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      take_sample(in_sample);
    end
  end

  // Each output transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (coef_expect_q.size() == 0) begin
        report_mismatch("coefficient with nothing expected", out_coefficient, 0);
      end else begin
        want_coef = coef_expect_q.pop_front();
        if (out_coefficient !== want_coef.coef)
          report_mismatch("coefficient", out_coefficient, want_coef.coef);
        if (out_freq_row !== want_coef.row)
          report_mismatch("freq_row", out_freq_row, want_coef.row);
        if (out_freq_col !== want_coef.col)
          report_mismatch("freq_col", out_freq_col, want_coef.col);
        if (out_block_end !== want_coef.last)
          report_mismatch("block_end", out_block_end, want_coef.last);
      end
    end
  end

  // Receiver stall: random bursts, one long hold-off on request, none when quiet.
  initial begin : rx_stall
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Guard against a hung run.
  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : main_flow
    real fval;
    int  wait_cnt;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_sample = '0;

    // Basis factors in signed Q1.14, rounded to nearest.
    for (int u = 0; u < BLOCK_DIM; u++) begin
      for (int x = 0; x < BLOCK_DIM; x++) begin
        if (u == 0) fval = 8192.0 * $sqrt(0.5);
        else fval = 8192.0 * $cos((2 * x + 1) * u * PI_VAL / (2.0 * BLOCK_DIM));
        basis_q14[u][x] = (fval >= 0.0) ? $rtoi(fval + 0.5) : -$rtoi(-fval + 0.5);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed blocks from the table.
    foreach (DIRECTED[i]) begin
      send_block(DIRECTED[i].pat, DIRECTED[i].level, DIRECTED[i].typed, DIRECTED[i].dc);
    end
    drain_block();

    // Random blocks; the first starts a long output hold-off while the
    // sender keeps offering the next one, which runs with no idling.
    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      if (blk == 0) hold_req = 1'b1;
      if (blk == RAND_BLOCKS - 1) quiet = 1'b1;
      send_block(RAND_PATS[$urandom_range(0, 3)], 8'd0, 1'b0, 29'sd0);
    end
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (coef_expect_q.size() != 0 && wait_cnt < 50000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (1100) @(posedge clk);
    if (coef_expect_q.size() != 0)
      report_mismatch("coefficients still expected at end", coef_expect_q.size(), 0);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/dct2d_pkg.sv
rtl/core/dct2d_ram.sv
rtl/core/dct2d_seq.sv
rtl/core/dct2d_mac.sv
rtl/core/dct_8x8_2d.sv
tb/sv/tb_dct_8x8_2d.sv
